// File: design/nsfe_pkg.sv
// nsfe_pkg: shared types, codes and functions for the NMEA sentence field extractor.
// No dependencies; the parser, output buffer and top level refer to it by scoped names.
package nsfe_pkg;

    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    localparam int HDR_BYTES = 6;
    localparam logic [7:0] LEN_MAX   = 8'd255;
    localparam logic [4:0] COMMA_MAX = 5'd31;

    localparam logic [7:0] MIN_LINE_LENGTH_RESET = 8'd50;

    // header byte 0 sits in the low bits, so the literals read back to front
    localparam logic [47:0] HDR_GGA = "AGGPG$";
    localparam logic [47:0] HDR_RMC = "CMRPG$";
    localparam logic [47:0] HDR_VTG = "GTVPG$";
    localparam logic [47:0] HDR_GSA = "ASGPG$";

    localparam logic [2:0] KIND_GGA   = 3'd0;
    localparam logic [2:0] KIND_RMC   = 3'd1;
    localparam logic [2:0] KIND_VTG   = 3'd2;
    localparam logic [2:0] KIND_GSA   = 3'd3;
    localparam logic [2:0] KIND_OTHER = 3'd4;

    localparam logic [2:0] TAG_TIME  = 3'd0;
    localparam logic [2:0] TAG_LAT   = 3'd1;
    localparam logic [2:0] TAG_LON   = 3'd2;
    localparam logic [2:0] TAG_ALT   = 3'd3;
    localparam logic [2:0] TAG_SPEED = 3'd4;
    localparam logic [2:0] TAG_DATE  = 3'd5;
    localparam logic [2:0] TAG_NONE  = 3'd7;

    localparam logic [1:0] RES_CHAR      = 2'd0;
    localparam logic [1:0] RES_FIELD_END = 2'd1;
    localparam logic [1:0] RES_LINE_END  = 2'd2;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [2:0] field_tag;
        logic [7:0] field_char;
        logic [4:0] field_number;
        logic [2:0] sentence_kind;
        logic       line_long_enough;
    } result_t;

    function automatic logic [2:0] classify(input logic [47:0] hdr);
        logic [2:0] k;
        k = KIND_OTHER;
        if (hdr == HDR_GSA) k = KIND_GSA;
        if (hdr == HDR_VTG) k = KIND_VTG;
        if (hdr == HDR_RMC) k = KIND_RMC;
        if (hdr == HDR_GGA) k = KIND_GGA;
        return k;
    endfunction

    function automatic logic [2:0] tag_of(input logic [2:0] kind, input logic [4:0] field);
        logic [2:0] t;
        t = TAG_NONE;
        case (kind)
            KIND_GGA:
            begin
                case (field)
                    5'd1:    t = TAG_TIME;
                    5'd2:    t = TAG_LAT;
                    5'd4:    t = TAG_LON;
                    5'd9:    t = TAG_ALT;
                    default: t = TAG_NONE;
                endcase
            end
            KIND_RMC:
            begin
                case (field)
                    5'd1:    t = TAG_TIME;
                    5'd3:    t = TAG_LAT;
                    5'd5:    t = TAG_LON;
                    5'd7:    t = TAG_SPEED;
                    5'd9:    t = TAG_DATE;
                    default: t = TAG_NONE;
                endcase
            end
            KIND_VTG:
            begin
                case (field)
                    5'd5:    t = TAG_SPEED;
                    5'd7:    t = TAG_SPEED;
                    default: t = TAG_NONE;
                endcase
            end
            default: t = TAG_NONE;
        endcase
        return t;
    endfunction

endpackage

// File: design/nsfe_ifs.sv
// Channel interfaces of the NMEA sentence field extractor: byte in, config write, result out.
// Does not refer to nsfe_pkg; the field widths here match those of nsfe_pkg::result_t.
interface nsfe_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface nsfe_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] min_line_length;
    modport source (output valid, output min_line_length, input ready);
    modport sink (input valid, input min_line_length, output ready);
endinterface

interface nsfe_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] result_kind;
    logic [2:0] field_tag;
    logic [7:0] field_char;
    logic [4:0] field_number;
    logic [2:0] sentence_kind;
    logic       line_long_enough;
    modport source (output valid, output result_kind, output field_tag, output field_char,
                    output field_number, output sentence_kind, output line_long_enough,
                    input ready);
    modport sink (input valid, input result_kind, input field_tag, input field_char,
                  input field_number, input sentence_kind, input line_long_enough,
                  output ready);
endinterface

// File: design/nmea_sentence_field_extractor_unit.sv
// NMEA sentence field extractor, top level. One received byte per word in.
// A result word is offered in the cycle after its byte is accepted, unless the output register is held.
// Throughput: one byte per cycle; input stalls whenever the skid register of the
// two-word output buffer holds a word, which happens only behind a stalled consumer.
// Reset (rst_n, async, active low): line state cleared, kind other, min length 50,
// output buffer empty.
module nmea_sentence_field_extractor_unit
(
    input  logic          clk,
    input  logic          rst_n,
    nsfe_byte_if.sink     rx,
    nsfe_cfg_if.sink      cfg,
    nsfe_result_if.source fields
);

    logic              space;
    logic              push;
    nsfe_pkg::result_t push_data;

    nsfe_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx),
        .cfg       (cfg),
        .space     (space),
        .push      (push),
        .push_data (push_data)
    );

    nsfe_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .space     (space),
        .fields    (fields)
    );

endmodule

// File: design/nsfe_parser.sv
// nsfe_parser: line state (header, length, comma count, kind) and per-byte result logic.
// Depends on nsfe_pkg and nsfe_ifs.
module nsfe_parser
(
    input  logic               clk,
    input  logic               rst_n,
    nsfe_byte_if.sink          rx,
    nsfe_cfg_if.sink           cfg,
    input  logic               space,
    output logic               push,
    output nsfe_pkg::result_t  push_data
);

    logic [47:0] hdr_reg, hdr_next, hdr_upd;
    logic [7:0]  len_reg, len_next;
    logic [4:0]  count_reg, count_next;
    logic [2:0]  kind_reg, kind_next;
    logic [7:0]  min_len_reg;

    logic       accept;
    logic       is_eol;
    logic       is_comma;
    logic [2:0] kind_cur;
    logic [2:0] tag;

    assign rx.ready  = space;
    assign cfg.ready = 1'b1;
    assign accept    = rx.valid & space;

    assign is_eol   = (rx.rx_byte == nsfe_pkg::CH_LF) || (rx.rx_byte == nsfe_pkg::CH_CR);
    assign is_comma = (rx.rx_byte == nsfe_pkg::CH_COMMA);

    always_comb
    begin
        hdr_upd = hdr_reg;
        for (int i = 0; i < nsfe_pkg::HDR_BYTES; i++)
        begin
            if (len_reg == 8'(i))
                hdr_upd[8*i +: 8] = rx.rx_byte;
        end
    end

    // the sentence is classed at the first comma, on the header including this byte
    assign kind_cur = (is_comma && count_reg == 5'd0) ? nsfe_pkg::classify(hdr_upd) : kind_reg;
    assign tag      = nsfe_pkg::tag_of(kind_cur, count_reg);

    always_comb
    begin
        push_data = '0;
        push_data.field_number  = count_reg;
        push_data.sentence_kind = kind_cur;
        if (is_eol)
        begin
            push_data.result_kind      = nsfe_pkg::RES_LINE_END;
            push_data.sentence_kind    = kind_reg;
            push_data.line_long_enough = (len_reg > min_len_reg);
        end
        else if (is_comma)
        begin
            push_data.result_kind = nsfe_pkg::RES_FIELD_END;
            push_data.field_tag   = tag;
        end
        else
        begin
            push_data.result_kind = nsfe_pkg::RES_CHAR;
            push_data.field_tag   = tag;
            push_data.field_char  = rx.rx_byte;
        end
    end

    assign push = accept && (is_eol || tag != nsfe_pkg::TAG_NONE);

    always_comb
    begin
        hdr_next   = hdr_reg;
        len_next   = len_reg;
        count_next = count_reg;
        kind_next  = kind_reg;
        if (accept)
        begin
            if (is_eol)
            begin
                hdr_next   = '0;
                len_next   = '0;
                count_next = '0;
                kind_next  = nsfe_pkg::KIND_OTHER;
            end
            else
            begin
                hdr_next = hdr_upd;
                if (len_reg != nsfe_pkg::LEN_MAX)
                    len_next = len_reg + 8'd1;
                if (is_comma)
                begin
                    kind_next = kind_cur;
                    if (count_reg != nsfe_pkg::COMMA_MAX)
                        count_next = count_reg + 5'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg     <= '0;
            len_reg     <= '0;
            count_reg   <= '0;
            kind_reg    <= nsfe_pkg::KIND_OTHER;
            min_len_reg <= nsfe_pkg::MIN_LINE_LENGTH_RESET;
        end
        else
        begin
            hdr_reg   <= hdr_next;
            len_reg   <= len_next;
            count_reg <= count_next;
            kind_reg  <= kind_next;
            if (cfg.valid)
                min_len_reg <= cfg.min_line_length;
        end
    end

    // kind is only set together with the first comma
    a_kind_needs_comma: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == 5'd0 |-> kind_reg == nsfe_pkg::KIND_OTHER)
        else $error("sentence kind set before first comma");

    a_eol_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_eol |=> len_reg == 8'd0 && count_reg == 5'd0 && hdr_reg == 48'd0)
        else $error("line state not cleared at line end");

    a_eol_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_eol |-> push)
        else $error("line end without a result word");

endmodule

// File: design/nsfe_out_buf.sv
// nsfe_out_buf: two-word output buffer (output register plus skid register).
// Depends on nsfe_pkg and nsfe_ifs.
module nsfe_out_buf
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  nsfe_pkg::result_t  push_data,
    output logic               space,
    nsfe_result_if.source      fields
);

    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    nsfe_pkg::result_t out_data_reg, out_data_next;
    nsfe_pkg::result_t skid_data_reg, skid_data_next;
    logic              pop;

    assign pop   = out_valid_reg & fields.ready;
    assign space = !skid_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_data_next  = push_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign fields.valid            = out_valid_reg;
    assign fields.result_kind      = out_data_reg.result_kind;
    assign fields.field_tag        = out_data_reg.field_tag;
    assign fields.field_char       = out_data_reg.field_char;
    assign fields.field_number     = out_data_reg.field_number;
    assign fields.sentence_kind    = out_data_reg.sentence_kind;
    assign fields.line_long_enough = out_data_reg.line_long_enough;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held with empty output register");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !skid_valid_reg)
        else $error("word pushed into full buffer");

    a_skid_moves_up: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && pop |=> out_valid_reg && !skid_valid_reg
                                  && out_data_reg == $past(skid_data_reg))
        else $error("skid word lost on pop");

endmodule

// File: tb/sv/tb_nmea_sentence_field_extractor_unit.sv
`timescale 1ns / 100ps
// Testbench for nmea_sentence_field_extractor_unit: directed rows, then random sentences under
// several minimum line lengths; each result word is checked against its row's word or a local predictor.
// Depends on nsfe_pkg and the channel interfaces in nsfe_ifs.sv.
module tb_nmea_sentence_field_extractor_unit;

    localparam int STALL_LIMIT = 500;

    typedef struct packed {
        logic [7:0]        ch;
        logic              pinned;
        nsfe_pkg::result_t want;
    } opening_row_t;

    localparam nsfe_pkg::result_t NO_WORD = '0;

    logic clk = 1'b0;
    logic rst_n;

    nsfe_byte_if   rx_ch ();
    nsfe_cfg_if    cfg_ch ();
    nsfe_result_if res_ch ();

    nmea_sentence_field_extractor_unit dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx_ch),
        .cfg    (cfg_ch),
        .fields (res_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // line tracker mirror
    logic [47:0] head_seen  = '0;
    logic [7:0]  line_len   = '0;
    logic [4:0]  commas     = '0;
    logic [2:0]  line_kind  = nsfe_pkg::KIND_OTHER;
    logic [7:0]  min_len    = nsfe_pkg::MIN_LINE_LENGTH_RESET;

    nsfe_pkg::result_t awaited_fields [$];
    int      mismatches  = 0;
    int      idle_cycles = 0;
    int      bytes_sent  = 0;

    // expectation pinned to the byte currently on offer, travels with it
    logic              pin_on   = 1'b0;
    nsfe_pkg::result_t pin_word = '0;

    bit src_calm      = 1'b0;
    int src_calm_left = 0;

    opening_row_t opening_rows [20] = '{
        {nsfe_pkg::CH_LF, 1'b1, nsfe_pkg::RES_LINE_END, 3'd0, 8'd0, 5'd0,
         nsfe_pkg::KIND_OTHER, 1'b0},
        {nsfe_pkg::CH_CR, 1'b1, nsfe_pkg::RES_LINE_END, 3'd0, 8'd0, 5'd0,
         nsfe_pkg::KIND_OTHER, 1'b0},
        {"$",      1'b0, NO_WORD},
        {"G",      1'b0, NO_WORD},
        {"P",      1'b0, NO_WORD},
        {"G",      1'b0, NO_WORD},
        {"G",      1'b0, NO_WORD},
        {"A",      1'b0, NO_WORD},
        {nsfe_pkg::CH_COMMA, 1'b0, NO_WORD},
        {"1", 1'b1, nsfe_pkg::RES_CHAR, nsfe_pkg::TAG_TIME, "1", 5'd1,
         nsfe_pkg::KIND_GGA, 1'b0},
        {nsfe_pkg::CH_COMMA, 1'b1, nsfe_pkg::RES_FIELD_END, nsfe_pkg::TAG_TIME, 8'd0, 5'd1,
         nsfe_pkg::KIND_GGA, 1'b0},
        {8'hFF, 1'b1, nsfe_pkg::RES_CHAR, nsfe_pkg::TAG_LAT, 8'hFF, 5'd2,
         nsfe_pkg::KIND_GGA, 1'b0},
        {8'h00, 1'b1, nsfe_pkg::RES_CHAR, nsfe_pkg::TAG_LAT, 8'h00, 5'd2,
         nsfe_pkg::KIND_GGA, 1'b0},
        {nsfe_pkg::CH_CR, 1'b1, nsfe_pkg::RES_LINE_END, 3'd0, 8'd0, 5'd2,
         nsfe_pkg::KIND_GGA, 1'b0},
        {nsfe_pkg::CH_LF, 1'b1, nsfe_pkg::RES_LINE_END, 3'd0, 8'd0, 5'd0,
         nsfe_pkg::KIND_OTHER, 1'b0},
        {"$",      1'b0, NO_WORD},
        {"G",      1'b0, NO_WORD},
        {nsfe_pkg::CH_COMMA, 1'b0, NO_WORD},
        {"7",      1'b0, NO_WORD},
        {nsfe_pkg::CH_LF, 1'b1, nsfe_pkg::RES_LINE_END, 3'd0, 8'd0, 5'd1,
         nsfe_pkg::KIND_OTHER, 1'b0}
    };

    function automatic logic [2:0] sort_header(input logic [47:0] h);
        if (h == nsfe_pkg::HDR_GGA)
            return nsfe_pkg::KIND_GGA;
        else if (h == nsfe_pkg::HDR_RMC)
            return nsfe_pkg::KIND_RMC;
        else if (h == nsfe_pkg::HDR_VTG)
            return nsfe_pkg::KIND_VTG;
        else if (h == nsfe_pkg::HDR_GSA)
            return nsfe_pkg::KIND_GSA;
        return nsfe_pkg::KIND_OTHER;
    endfunction

    function automatic logic [2:0] tag_for(input logic [2:0] kind, input logic [4:0] idx);
        logic [2:0] t;
        t = nsfe_pkg::TAG_NONE;
        if (kind == nsfe_pkg::KIND_GGA)
            t = (idx == 5'd1) ? nsfe_pkg::TAG_TIME : (idx == 5'd2) ? nsfe_pkg::TAG_LAT :
                (idx == 5'd4) ? nsfe_pkg::TAG_LON  : (idx == 5'd9) ? nsfe_pkg::TAG_ALT :
                nsfe_pkg::TAG_NONE;
        else if (kind == nsfe_pkg::KIND_RMC)
            t = (idx == 5'd1) ? nsfe_pkg::TAG_TIME  : (idx == 5'd3) ? nsfe_pkg::TAG_LAT :
                (idx == 5'd5) ? nsfe_pkg::TAG_LON   : (idx == 5'd7) ? nsfe_pkg::TAG_SPEED :
                (idx == 5'd9) ? nsfe_pkg::TAG_DATE  : nsfe_pkg::TAG_NONE;
        else if (kind == nsfe_pkg::KIND_VTG && (idx == 5'd5 || idx == 5'd7))
            t = nsfe_pkg::TAG_SPEED;
        return t;
    endfunction

    // advances the mirror by one byte; returns 1 when a result word is due
    function automatic bit extract_step(input logic [7:0] b, output nsfe_pkg::result_t r);
        logic [2:0] t;
        r = '0;
        if (b == nsfe_pkg::CH_LF || b == nsfe_pkg::CH_CR)
        begin
            r.result_kind      = nsfe_pkg::RES_LINE_END;
            r.field_number     = commas;
            r.sentence_kind    = line_kind;
            r.line_long_enough = (line_len > min_len);
            head_seen = '0;
            line_len  = '0;
            commas    = '0;
            line_kind = nsfe_pkg::KIND_OTHER;
            return 1'b1;
        end
        if (line_len < nsfe_pkg::HDR_BYTES)
            head_seen[line_len * 8 +: 8] = b;
        if (line_len != nsfe_pkg::LEN_MAX)
            line_len = line_len + 8'd1;
        if (b == nsfe_pkg::CH_COMMA)
        begin
            if (commas == 5'd0)
                line_kind = sort_header(head_seen);
            t = tag_for(line_kind, commas);
            r.result_kind   = nsfe_pkg::RES_FIELD_END;
            r.field_tag     = t;
            r.field_number  = commas;
            r.sentence_kind = line_kind;
            if (commas != nsfe_pkg::COMMA_MAX)
                commas = commas + 5'd1;
            return (t != nsfe_pkg::TAG_NONE);
        end
        t = tag_for(line_kind, commas);
        r.result_kind   = nsfe_pkg::RES_CHAR;
        r.field_tag     = t;
        r.field_char    = b;
        r.field_number  = commas;
        r.sentence_kind = line_kind;
        return (t != nsfe_pkg::TAG_NONE);
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // scoreboard: check outgoing words first, then predict from the incoming byte
    always @(posedge clk)
    begin
        nsfe_pkg::result_t want;
        nsfe_pkg::result_t pred;
        bit                due;
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (awaited_fields.size() == 0)
                begin
                    $error("result word with nothing expected: kind %0d char %0d",
                           res_ch.result_kind, res_ch.field_char);
                    mismatches++;
                end
                else
                begin
                    want = awaited_fields.pop_front();
                    check_field("result_kind", want.result_kind, res_ch.result_kind);
                    check_field("field_tag", want.field_tag, res_ch.field_tag);
                    check_field("field_char", want.field_char, res_ch.field_char);
                    check_field("field_number", want.field_number, res_ch.field_number);
                    check_field("sentence_kind", want.sentence_kind, res_ch.sentence_kind);
                    check_field("line_long_enough", want.line_long_enough,
                                res_ch.line_long_enough);
                end
            end
            if (rx_ch.valid && rx_ch.ready)
            begin
                due = extract_step(rx_ch.rx_byte, pred);
                if (pin_on)
                    awaited_fields.push_back(pin_word);
                else if (due)
                    awaited_fields.push_back(pred);
            end
            if (cfg_ch.valid && cfg_ch.ready)
                min_len = cfg_ch.min_line_length;
        end
    end

    always @(posedge clk)
    begin
        if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("[nmea_sentence_field_extractor_unit] ERROR");
            $finish;
        end
    end

    // result consumer: random stall before each word, with calm stretches
    initial
    begin
        int stall;
        int calm_left;
        bit calm;
        calm_left = 0;
        calm = 1'b0;
        res_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (calm_left == 0)
            begin
                calm = ($urandom_range(0, 2) == 0);
                calm_left = $urandom_range(8, 40);
            end
            calm_left--;
            stall = calm ? 0 : $urandom_range(0, 5);
            if (stall != 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_ch.valid);
        end
    end

    task automatic send_byte(input logic [7:0] b, input bit pinned,
                             input nsfe_pkg::result_t want);
        int gap;
        if (src_calm_left == 0)
        begin
            src_calm = ($urandom_range(0, 2) == 0);
            src_calm_left = $urandom_range(8, 40);
        end
        src_calm_left--;
        gap = src_calm ? 0 : $urandom_range(0, 5);
        if (gap != 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        pin_on        <= pinned;
        pin_word      <= want;
        do
            @(posedge clk);
        while (!rx_ch.ready);
        bytes_sent++;
    endtask

    // one sentence: mostly known headers, some near misses, short or noisy headers
    task automatic send_line(input int n_fields, input int len_lo, input int len_hi);
        logic [47:0] head;
        logic [7:0]  c;
        int          head_len;
        int          i;
        int          j;
        int          pick;
        head_len = nsfe_pkg::HDR_BYTES;
        case ($urandom_range(0, 9))
            0, 1: head = nsfe_pkg::HDR_GGA;
            2, 3: head = nsfe_pkg::HDR_RMC;
            4, 5: head = nsfe_pkg::HDR_VTG;
            6:    head = nsfe_pkg::HDR_GSA;
            7:
            begin
                head = $urandom_range(0, 1) ? nsfe_pkg::HDR_GGA : nsfe_pkg::HDR_VTG;
                pick = $urandom_range(0, 47);
                head[pick] = ~head[pick];
            end
            8:
            begin
                head = {16'($urandom), 32'($urandom)};
                head_len = $urandom_range(0, 5);
            end
            default: head = {16'($urandom), 32'($urandom)};
        endcase
        for (i = 0; i < head_len; i++)
            send_byte(head[i * 8 +: 8], 1'b0, NO_WORD);
        for (i = 0; i < n_fields; i++)
        begin
            send_byte(nsfe_pkg::CH_COMMA, 1'b0, NO_WORD);
            for (j = $urandom_range(len_lo, len_hi); j > 0; j--)
            begin
                pick = $urandom_range(0, 7);
                if (pick < 5)
                    c = 8'($urandom_range(48, 57));
                else if (pick == 5)
                    c = ".";
                else if (pick == 6)
                    c = 8'($urandom_range(65, 90));
                else
                    c = 8'($urandom_range(0, 255));
                send_byte(c, 1'b0, NO_WORD);
            end
        end
        // no terminator at all lets the next sentence run on into this line
        case ($urandom_range(0, 3))
            0:
            begin
                send_byte(nsfe_pkg::CH_CR, 1'b0, NO_WORD);
                send_byte(nsfe_pkg::CH_LF, 1'b0, NO_WORD);
            end
            1: send_byte(nsfe_pkg::CH_CR, 1'b0, NO_WORD);
            2: send_byte(nsfe_pkg::CH_LF, 1'b0, NO_WORD);
            default: ;
        endcase
    endtask

    task automatic write_min_length(input logic [7:0] v);
        rx_ch.valid <= 1'b0;
        @(posedge clk);
        while (awaited_fields.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_ch.valid           <= 1'b1;
        cfg_ch.min_line_length <= v;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    initial
    begin
        int         r;
        int         phase;
        int         goal;
        logic [7:0] setting;
        rst_n                  = 1'b0;
        rx_ch.valid            = 1'b0;
        rx_ch.rx_byte          = 8'd0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.min_line_length = 8'd0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        for (r = 0; r < $size(opening_rows); r++)
            send_byte(opening_rows[r].ch, opening_rows[r].pinned, opening_rows[r].want);

        for (phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0:       setting = 8'd0;
                1:       setting = 8'd254;
                2:       setting = 8'd255;
                3:       setting = 8'($urandom_range(1, 253));
                default: setting = nsfe_pkg::MIN_LINE_LENGTH_RESET;
            endcase
            write_min_length(setting);
            // a line long enough to saturate both the length and the comma count
            if (setting == 8'd254)
                send_line(32, 7, 7);
            goal = bytes_sent + 50;
            while (bytes_sent < goal)
                send_line($urandom_range(0, 14), 0, 5);
        end

        rx_ch.valid <= 1'b0;
        @(posedge clk);
        while (awaited_fields.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (awaited_fields.size() != 0)
        begin
            $error("%0d result words never arrived", awaited_fields.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("[nmea_sentence_field_extractor_unit] OK");
        else
            $display("[nmea_sentence_field_extractor_unit] ERROR");
        $finish;
    end

endmodule

// File: sim.f
design/nsfe_pkg.sv
design/nsfe_ifs.sv
design/nsfe_parser.sv
design/nsfe_out_buf.sv
design/nmea_sentence_field_extractor_unit.sv
tb/sv/tb_nmea_sentence_field_extractor_unit.sv
